// ===== hdl/dense_layer_forward_unit_defines.svh =====
// Assertion macros shared by the dense layer forward unit.
`ifndef DENSE_LAYER_FORWARD_UNIT_DEFINES_SVH
`define DENSE_LAYER_FORWARD_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define DLF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, off while in reset
`define DLF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== hdl/dlf_pkg.sv =====
// Types and constants of the dense layer forward unit.
package dlf_pkg;
	localparam int TOK_IDX_W = 6;

	localparam logic [1:0] OP_WEIGHT = 2'd0;
	localparam logic [1:0] OP_BIAS   = 2'd1;
	localparam logic [1:0] OP_ELEM   = 2'd2;

	localparam logic [1:0] ACT_SIGMOID = 2'd0;
	localparam logic [1:0] ACT_RELU    = 2'd1;
	localparam logic [1:0] ACT_TANH    = 2'd2;

	localparam logic [1:0] REG_INPUTS  = 2'd0;
	localparam logic [1:0] REG_NEURONS = 2'd1;
	localparam logic [1:0] REG_MODE    = 2'd2;

	// e^(-1/16) in Q0.32
	localparam logic [31:0] EXP_STEP = 32'd4034748381;

	typedef struct packed {
		logic [1:0]         op;
		logic [3:0]         neuron_sel;
		logic [3:0]         input_sel;
		logic signed [15:0] value;
		logic               vector_done;
	} item_t;

	typedef struct packed {
		logic [3:0]         out_neuron;
		logic signed [15:0] activation;
		logic               last_result;
	} result_t;

	typedef struct packed {
		logic                 we_weight;
		logic                 we_bias;
		logic [3:0]           neuron_sel;
		logic [TOK_IDX_W-1:0] addr;
		logic signed [15:0]   data;
	} wr_t;

	typedef struct packed {
		logic                 valid;
		logic                 first;
		logic                 last;
		logic [TOK_IDX_W-1:0] idx;
		logic signed [15:0]   x;
	} tok_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] neuron;
		logic       last;
		logic [1:0] mode;
	} act_req_t;

	typedef enum logic [1:0] {ST_IDLE, ST_FEED, ST_WAIT, ST_DRAIN} ctrl_state_t;
	typedef enum logic [2:0] {A_IDLE, A_PREP, A_EXPO, A_DIVI, A_HOLD} act_state_t;
endpackage

// ===== hdl/dlf_cell.sv =====
// One neuron cell: weight row, bias and multiply-accumulate; passes input tokens on.
module dlf_cell #(
	parameter int IDX        = 0,
	parameter int MAX_INPUTS = 16,
	parameter int AW         = 38
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dlf_pkg::wr_t         wr,
	input  dlf_pkg::tok_t        tok_in,
	output dlf_pkg::tok_t        tok_out,
	output logic signed [AW-1:0] acc
);
	import dlf_pkg::*;

	localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

	logic signed [15:0]   wmem [MAX_INPUTS];
	logic signed [15:0]   bias_q;
	logic signed [15:0]   w_s1;
	tok_t                 tok_s1;
	logic                 v_s2;
	logic                 first_s2;
	logic signed [31:0]   prod_s2;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] bias_ext;
	logic signed [AW-1:0] prod_ext;
	logic                 hit;

	assign hit      = (32'(wr.neuron_sel) == IDX);
	assign bias_ext = AW'(bias_q);
	assign prod_ext = AW'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			v_s2   <= 1'b0;
		end else begin
			tok_s1 <= tok_in;
			v_s2   <= tok_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we_weight && hit) begin
			wmem[wr.addr[IW-1:0]] <= wr.data;
		end
		if (wr.we_bias && hit) begin
			bias_q <= wr.data;
		end
		w_s1     <= wmem[tok_in.idx[IW-1:0]];
		first_s2 <= tok_s1.first;
		prod_s2  <= tok_s1.x * w_s1;
		// first product seeds the sum with the bias in Q8.24
		if (v_s2) begin
			acc_q <= first_s2 ? ((bias_ext <<< 12) + prod_ext) : (acc_q + prod_ext);
		end
	end

	assign tok_out = tok_s1;
	assign acc     = acc_q;
endmodule

// ===== hdl/dlf_act.sv =====
// Activation unit: rounding, ReLU, and sigmoid/tanh by exponent iteration and division.
module dlf_act #(
	parameter int AW = 38
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dlf_pkg::act_req_t    req,
	input  logic signed [AW-1:0] acc,
	output logic                 ready,
	output dlf_pkg::result_t     result,
	output logic                 result_valid,
	input  logic                 result_ready
);
	import dlf_pkg::*;

	localparam int ZW = AW - 12;
	localparam logic signed [ZW-1:0] ZMAX = ZW'(32767);
	localparam logic signed [ZW-1:0] ZMIN = -ZW'(32768);

	act_state_t state_q, state_d;

	logic signed [AW-1:0] acc_q;
	logic [3:0]           neuron_q;
	logic                 last_q;
	logic                 relu_q;
	logic                 tanh_q;
	logic                 kge_q;
	logic [32:0]          f_q;
	logic [8:0]           cnt_q;
	logic [45:0]          rem_q;
	logic [33:0]          d_q;
	logic [3:0]           bit_q;
	logic [12:0]          quo_q;
	logic signed [15:0]   res_q;
	result_t              out_q;
	logic                 out_v_q;

	logic signed [AW-1:0] rnd;
	logic signed [ZW-1:0] z;
	logic signed [15:0]   zc;
	logic signed [15:0]   relu_val;
	logic [7:0]           k;
	logic [7:0]           m;
	logic [8:0]           steps;
	logic [63:0]          prod;
	logic [33:0]          d_new;
	logic [45:0]          num;
	logic [45:0]          trial;
	logic                 ge;
	logic [12:0]          quo_nxt;
	logic                 take;
	logic                 ld_out;

	// round to Q4.12 and form the table index
	always_comb begin
		rnd = acc_q + AW'(2048);
		z   = rnd[AW-1:12];
		if (z > ZMAX) begin
			zc = 16'sh7fff;
		end else if (z < ZMIN) begin
			zc = -16'sh8000;
		end else begin
			zc = z[15:0];
		end
		if (z < 0) begin
			relu_val = '0;
		end else begin
			relu_val = zc;
		end
		k     = {~zc[15], zc[14:8]};
		m     = k[7] ? {1'b0, k[6:0]} : (8'd128 - k);
		steps = tanh_q ? {m, 1'b0} : {1'b0, m};
	end

	// exponent step and divider setup
	always_comb begin
		prod  = 64'(f_q[31:0]) * 64'(EXP_STEP);
		d_new = 34'(f_q) + 34'h1_0000_0000;
		if (tanh_q) begin
			num = (46'(34'h1_0000_0000 - 34'(f_q)) << 12) + 46'(d_new >> 1);
		end else if (kge_q) begin
			num = (46'(1) << 44) + 46'(d_new >> 1);
		end else begin
			num = (46'(f_q) << 12) + 46'(d_new >> 1);
		end
		trial   = 46'(d_q) << bit_q;
		ge      = (rem_q >= trial);
		quo_nxt = quo_q | (13'(ge) << bit_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			A_IDLE: if (req.valid) state_d = A_PREP;
			A_PREP: state_d = relu_q ? A_HOLD : A_EXPO;
			A_EXPO: if (cnt_q == '0) state_d = A_DIVI;
			A_DIVI: if (bit_q == '0) state_d = A_HOLD;
			A_HOLD: if (!out_v_q || result_ready) state_d = A_IDLE;
			default: state_d = A_IDLE;
		endcase
	end

	always_comb begin
		ready  = (state_q == A_IDLE);
		take   = ready && req.valid;
		ld_out = (state_q == A_HOLD) && (!out_v_q || result_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_out) begin
				out_v_q <= 1'b1;
			end else if (result_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			acc_q    <= acc;
			neuron_q <= req.neuron;
			last_q   <= req.last;
			relu_q   <= (req.mode == ACT_RELU);
			tanh_q   <= (req.mode == ACT_TANH);
		end
		if (state_q == A_PREP) begin
			res_q <= relu_val;
			kge_q <= k[7];
			// first multiply by the step from one is exact
			if (steps == '0) begin
				f_q   <= 33'h1_0000_0000;
				cnt_q <= '0;
			end else begin
				f_q   <= 33'(EXP_STEP);
				cnt_q <= steps - 9'd1;
			end
		end
		if (state_q == A_EXPO) begin
			if (cnt_q == '0) begin
				d_q   <= d_new;
				rem_q <= num;
				bit_q <= 4'd12;
				quo_q <= '0;
			end else begin
				f_q   <= {1'b0, prod[63:32]};
				cnt_q <= cnt_q - 9'd1;
			end
		end
		if (state_q == A_DIVI) begin
			if (ge) begin
				rem_q <= rem_q - trial;
			end
			quo_q <= quo_nxt;
			bit_q <= bit_q - 4'd1;
			if (bit_q == '0) begin
				res_q <= (tanh_q && !kge_q) ? -16'(quo_nxt) : 16'(quo_nxt);
			end
		end
		if (ld_out) begin
			out_q.out_neuron  <= neuron_q;
			out_q.activation  <= res_q;
			out_q.last_result <= last_q;
		end
	end

	assign result       = out_q;
	assign result_valid = out_v_q;
endmodule

// ===== hdl/dense_layer_forward_unit.sv =====
// Dense layer forward unit: a fully connected layer over a chain of neuron cells.
// Weight, bias and element items are taken while idle. A marked last element starts a run:
// feed of the inputs in use, a pass through the cell chain, then one result per neuron from
// the activation unit: ReLU goes straight to the output, sigmoid takes m exponent steps and
// tanh 2m before the division, m = |k - 128| of the table index (up to 128).
// Reset sets inputs_in_use and neurons_in_use to 16 and the mode to sigmoid; stores are undefined.
`include "dense_layer_forward_unit_defines.svh"

module dense_layer_forward_unit #(
	parameter int MAX_INPUTS  = 16,
	parameter int MAX_NEURONS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  dlf_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output dlf_pkg::result_t result,
	input  logic             cfg_wen,
	input  logic [1:0]       cfg_index,
	input  logic [4:0]       cfg_data
);
	import dlf_pkg::*;

	localparam int IW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int NW  = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
	localparam int CIW = $clog2(MAX_INPUTS + 1);
	localparam int CNW = $clog2(MAX_NEURONS + 1);
	localparam int AW  = 33 + CIW;

	ctrl_state_t state_q, state_d;

	logic [4:0]         inputs_in_use_q;
	logic [4:0]         neurons_in_use_q;
	logic [1:0]         activation_mode_q;
	logic [CIW-1:0]     ni_eff;
	logic [CNW-1:0]     nn_eff;

	logic signed [15:0] in_mem [MAX_INPUTS];
	logic signed [15:0] in_rd_q;
	logic [CIW-1:0]     j_q;
	logic [CNW-1:0]     n_q;
	logic               feed_v_s1;
	logic               first_s1;
	logic               last_s1;
	logic [TOK_IDX_W-1:0] idx_s1;
	logic               fin_s1;
	logic               fin_s2;

	logic               take;
	logic               in_ok;
	logic               start;
	logic               feed_last;
	logic               drain_last;
	logic               feed_en;
	wr_t                wr;
	tok_t               tok [MAX_NEURONS + 1];
	logic signed [AW-1:0] accs [MAX_NEURONS];
	act_req_t           act_req;
	logic               act_ready;

	always_comb begin
		if (inputs_in_use_q == '0) begin
			ni_eff = CIW'(1);
		end else if (32'(inputs_in_use_q) > MAX_INPUTS) begin
			ni_eff = CIW'(MAX_INPUTS);
		end else begin
			ni_eff = CIW'(inputs_in_use_q);
		end
		if (neurons_in_use_q == '0) begin
			nn_eff = CNW'(1);
		end else if (32'(neurons_in_use_q) > MAX_NEURONS) begin
			nn_eff = CNW'(MAX_NEURONS);
		end else begin
			nn_eff = CNW'(neurons_in_use_q);
		end
	end

	always_comb begin
		take       = item_valid && item_ready;
		in_ok      = (32'(item.input_sel) < MAX_INPUTS);
		start      = take && (item.op == OP_ELEM) && item.vector_done;
		feed_last  = (j_q == ni_eff - CIW'(1));
		drain_last = (n_q == nn_eff - CNW'(1));
		wr.we_weight  = take && (item.op == OP_WEIGHT) && in_ok;
		wr.we_bias    = take && (item.op == OP_BIAS);
		wr.neuron_sel = item.neuron_sel;
		wr.addr       = TOK_IDX_W'(item.input_sel);
		wr.data       = item.value;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_FEED;
			ST_FEED:  if (feed_last) state_d = ST_WAIT;
			ST_WAIT:  if (fin_s2) state_d = ST_DRAIN;
			ST_DRAIN: if (act_ready && drain_last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready     = (state_q == ST_IDLE);
		feed_en        = (state_q == ST_FEED);
		act_req.valid  = (state_q == ST_DRAIN);
		act_req.neuron = 4'(n_q);
		act_req.last   = drain_last;
		act_req.mode   = activation_mode_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			inputs_in_use_q   <= 5'd16;
			neurons_in_use_q  <= 5'd16;
			activation_mode_q <= ACT_SIGMOID;
			j_q               <= '0;
			n_q               <= '0;
			feed_v_s1         <= 1'b0;
			fin_s1            <= 1'b0;
			fin_s2            <= 1'b0;
		end else begin
			state_q   <= state_d;
			feed_v_s1 <= feed_en;
			fin_s1    <= tok[MAX_NEURONS].valid && tok[MAX_NEURONS].last;
			fin_s2    <= fin_s1;
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_INPUTS:  inputs_in_use_q   <= cfg_data;
					REG_NEURONS: neurons_in_use_q  <= cfg_data;
					REG_MODE:    activation_mode_q <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (start) begin
				j_q <= '0;
			end else if (feed_en) begin
				j_q <= j_q + CIW'(1);
			end
			if (state_q == ST_WAIT) begin
				n_q <= '0;
			end else if (act_req.valid && act_ready) begin
				n_q <= n_q + CNW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && (item.op == OP_ELEM) && in_ok) begin
			in_mem[IW'(item.input_sel)] <= item.value;
		end
		in_rd_q  <= in_mem[j_q[IW-1:0]];
		first_s1 <= (j_q == '0);
		last_s1  <= feed_last;
		idx_s1   <= TOK_IDX_W'(j_q);
	end

	always_comb begin
		tok[0].valid = feed_v_s1;
		tok[0].first = first_s1;
		tok[0].last  = last_s1;
		tok[0].idx   = idx_s1;
		tok[0].x     = in_rd_q;
	end

	for (genvar i = 0; i < MAX_NEURONS; i++) begin : g_cell
		dlf_cell #(
			.IDX        (i),
			.MAX_INPUTS (MAX_INPUTS),
			.AW         (AW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr),
			.tok_in  (tok[i]),
			.tok_out (tok[i + 1]),
			.acc     (accs[i])
		);
	end

	dlf_act #(
		.AW (AW)
	) u_act (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (act_req),
		.acc          (accs[n_q[NW-1:0]]),
		.ready        (act_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

	`DLF_ASSERT_IMP(a_fin_in_wait, fin_s2, state_q == ST_WAIT, "chain finished outside wait")
	`DLF_ASSERT_IMP(a_drain_range, act_req.valid && act_ready, 32'(n_q) < 32'(nn_eff), "neuron index past count")
	`DLF_ASSERT_NXT(a_feed_token, state_q == ST_FEED, tok[0].valid, "feed slot gave no token")
endmodule

// ===== bench/tb_dense_layer_forward_unit.sv =====
// Self-checking testbench for the dense layer forward unit: random items, stalls, predicted results.
`timescale 1ns / 100ps

module tb_dense_layer_forward_unit;
	import dlf_pkg::*;

	localparam int N_IN       = 16;
	localparam int N_NEU      = 16;
	localparam int IDLE_LIMIT = 20000;
	localparam longint unsigned ONE_Q32 = 64'd4294967296;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;
	logic    cfg_wen = 1'b0;
	logic [1:0] cfg_index = REG_INPUTS;
	logic [4:0] cfg_data = 5'd0;

	dense_layer_forward_unit #(.MAX_INPUTS(N_IN), .MAX_NEURONS(N_NEU)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// layer shadow: stores, settings and activation tables
	logic signed [15:0] weights [N_NEU*N_IN];
	logic signed [15:0] biases [N_NEU];
	logic signed [15:0] elems [N_IN];
	logic [4:0]  in_cnt_reg = 5'd16;
	logic [4:0]  neu_cnt_reg = 5'd16;
	logic [1:0]  mode_reg = ACT_SIGMOID;
	logic signed [15:0] sig_lut [256];
	logic signed [15:0] tanh_lut [256];

	item_t   pending_items [$];
	result_t expected_results [$];
	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_vectors = 0;

	function automatic longint unsigned decay(int steps);
		longint unsigned f;
		f = ONE_Q32;
		for (int i = 0; i < steps; i++)
			f = (f * 64'd4034748381) >> 32;
		return f;
	endfunction

	task automatic build_luts();
		int m;
		longint unsigned e, d, mag;
		for (int k = 0; k < 256; k++) begin
			m = (k < 128) ? 128 - k : k - 128;
			e = decay(m);
			d = ONE_Q32 + e;
			if (k >= 128)
				sig_lut[k] = 16'(((ONE_Q32 << 12) + d / 2) / d);
			else
				sig_lut[k] = 16'((e * 4096 + d / 2) / d);
			e = decay(2 * m);
			d = ONE_Q32 + e;
			mag = ((ONE_Q32 - e) * 4096 + d / 2) / d;
			tanh_lut[k] = (k < 128) ? -16'(mag) : 16'(mag);
		end
	endtask

	function automatic int clamp_cnt(logic [4:0] v);
		if (v == 0)
			return 1;
		return (v > 16) ? 16 : int'(v);
	endfunction

	function automatic logic signed [15:0] neuron_value(int n, int ni);
		longint acc, z;
		int k;
		acc = longint'(biases[n]) * 4096;
		for (int j = 0; j < ni; j++)
			acc += longint'(elems[j]) * longint'(weights[n*N_IN + j]);
		z = (acc + 2048) >>> 12;
		if (mode_reg == ACT_RELU)
			return (z < 0) ? 16'sd0 : ((z > 32767) ? 16'sd32767 : 16'(z));
		if (z < -32768)
			z = -32768;
		if (z > 32767)
			z = 32767;
		k = int'((z + 32768) >>> 8);
		return (mode_reg == ACT_TANH) ? tanh_lut[k] : sig_lut[k];
	endfunction

	// update the shadow stores and queue the results this item causes
	task automatic predict_layer(item_t it);
		int ni, nn;
		result_t r;
		case (it.op)
			OP_WEIGHT: weights[it.neuron_sel*N_IN + it.input_sel] = it.value;
			OP_BIAS:   biases[it.neuron_sel] = it.value;
			OP_ELEM: begin
				elems[it.input_sel] = it.value;
				if (it.vector_done) begin
					ni = clamp_cnt(in_cnt_reg);
					nn = clamp_cnt(neu_cnt_reg);
					n_vectors++;
					for (int n = 0; n < nn; n++) begin
						r.out_neuron = 4'(n);
						r.activation = neuron_value(n, ni);
						r.last_result = (n == nn - 1);
						expected_results.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endtask

	// sender: bursts with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (item_valid && item_ready) begin
				predict_layer(item);
				n_items++;
			end
			if (!item_valid || item_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					item_valid <= 1'b0;
				end else if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
					item_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
					burst_left <= burst_left - 1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random ready duty of 100, 70, 30 or 5 percent, picked anew on a duty counter
	int duty = 100;
	int duty_cnt = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			duty_cnt <= 0;
		end else begin
			duty_cnt <= duty_cnt + 1;
			if (duty_cnt % 64 == 0) begin
				case ($urandom_range(0, 3))
					0: duty = 100;
					1: duty = 70;
					2: duty = 30;
					default: duty = 5;
				endcase
			end
			result_ready <= ($urandom_range(1, 100) <= duty);
		end
	end

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && result_ready) begin
			n_results++;
			if (expected_results.size() == 0) begin
				$error("unexpected result: neuron %0d activation %0d", result.out_neuron,
					result.activation);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.out_neuron !== exp_r.out_neuron) begin
					$error("out_neuron: expected %0d, got %0d", exp_r.out_neuron,
						result.out_neuron);
					errors++;
				end
				if (result.activation !== exp_r.activation) begin
					$error("activation: expected %0d, got %0d", exp_r.activation,
						result.activation);
					errors++;
				end
				if (result.last_result !== exp_r.last_result) begin
					$error("last_result: expected %0d, got %0d", exp_r.last_result,
						result.last_result);
					errors++;
				end
			end
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic item_t make_item(logic [1:0] op, int ns, int is, int val, bit done);
		item_t it;
		it.op = op;
		it.neuron_sel = 4'(ns);
		it.input_sel = 4'(is);
		it.value = 16'(val);
		it.vector_done = done;
		return it;
	endfunction

	function automatic int rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 65535) - 32768;
			1: return ($urandom_range(0, 1) == 0) ? 32767 : -32768;
			default: return $urandom_range(0, 2047) - 1024;
		endcase
	endfunction

	// hold until the layer has drained every result
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() > 0 || item_valid || expected_results.size() > 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [4:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_INPUTS:  in_cnt_reg = val;
			REG_NEURONS: neu_cnt_reg = val;
			default:     mode_reg = val[1:0];
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic random_phase(int count);
		int sent, ni;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) < 6) begin
				// well-formed vector: a few parameter updates, then elements in order
				repeat ($urandom_range(0, 4)) begin
					pending_items.push_back(make_item($urandom_range(0, 1) ? OP_WEIGHT : OP_BIAS,
						$urandom_range(0, 15), $urandom_range(0, 15), rand_value(),
						$urandom_range(0, 1)));
					sent++;
				end
				ni = clamp_cnt(in_cnt_reg);
				for (int j = 0; j < ni; j++) begin
					pending_items.push_back(make_item(OP_ELEM, $urandom_range(0, 15), j,
						rand_value(), j == ni - 1));
					sent++;
				end
			end else begin
				pending_items.push_back(make_item(2'($urandom_range(0, 3)),
					$urandom_range(0, 15), $urandom_range(0, 15), rand_value(),
					$urandom_range(0, 7) == 0));
				sent++;
			end
		end
		wait_drained();
	endtask

	initial begin
		build_luts();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every store entry so no later sum reads an unwritten one
		for (int n = 0; n < N_NEU; n++) begin
			for (int j = 0; j < N_IN; j++)
				pending_items.push_back(make_item(OP_WEIGHT, n, j, rand_value(), 1'b0));
			pending_items.push_back(make_item(OP_BIAS, n, 0, rand_value(), 1'b0));
		end
		for (int j = 0; j < N_IN; j++)
			pending_items.push_back(make_item(OP_ELEM, 0, j, rand_value(), 1'b0));
		wait_drained();

		// directed: extremes, ignored ops, done flag off elements
		pending_items.push_back(make_item(OP_WEIGHT, 0, 0, -32768, 1'b1));
		pending_items.push_back(make_item(OP_WEIGHT, 15, 15, 32767, 1'b0));
		pending_items.push_back(make_item(OP_BIAS, 0, 0, 32767, 1'b1));
		pending_items.push_back(make_item(OP_BIAS, 15, 15, -32768, 1'b0));
		pending_items.push_back(make_item(2'd3, 15, 15, -1, 1'b1));
		pending_items.push_back(make_item(2'd3, 0, 0, 0, 1'b0));
		for (int j = 0; j < N_IN; j++)
			pending_items.push_back(make_item(OP_ELEM, 15 - j, j,
				(j % 3 == 0) ? 32767 : ((j % 3 == 1) ? -32768 : 0), j == N_IN - 1));
		pending_items.push_back(make_item(OP_ELEM, 5, 0, 0, 1'b1));
		wait_drained();

		random_phase(30);
		write_reg(REG_INPUTS, 5'd1);
		write_reg(REG_NEURONS, 5'd1);
		write_reg(REG_MODE, ACT_RELU);
		random_phase(25);
		write_reg(REG_INPUTS, 5'd0);
		write_reg(REG_NEURONS, 5'd31);
		write_reg(REG_MODE, ACT_TANH);
		random_phase(25);
		write_reg(REG_INPUTS, 5'd31);
		write_reg(REG_NEURONS, 5'd0);
		write_reg(REG_MODE, 2'd3);
		random_phase(25);
		repeat (4) begin
			write_reg(REG_INPUTS, 5'($urandom_range(1, 16)));
			write_reg(REG_NEURONS, 5'($urandom_range(1, 16)));
			write_reg(REG_MODE, 2'($urandom_range(0, 3)));
			random_phase(25);
		end

		$display("covered %0d items, %0d vectors, %0d results checked", n_items, n_vectors,
			n_results);
		$display("count settings from 0 to 31 and all four activation modes were exercised");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
